### hdl/gca_pkg.sv
// Shared widths, constants and helpers for the glyph cell allocator.
package gca_pkg;

  localparam int KEY_W      = 21;
  localparam int CELL_OUT_W = 10;
  localparam int GRID_W     = 5;
  localparam int COORD_W    = 13;
  localparam int CELL_SHIFT = 7;   // a cell spans 128 coordinate units

  localparam logic [KEY_W-1:0] CP_NULL  = 21'd0;
  localparam logic [KEY_W-1:0] CP_SPACE = 21'd32;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COORD_W-1:0] coord_t;

  // Codepoints that always land in the reserved blank cell
  function automatic logic is_blank(input key_t cp);
    is_blank = (cp == CP_NULL) || (cp == CP_SPACE);
  endfunction

  // Leading edge of a cell plus the one-unit inset, wrapped to the field
  function automatic coord_t coord_lo(input logic [COORD_W-CELL_SHIFT-1:0] pos);
    coord_lo = {pos, 7'b0000001};
  endfunction

  // Trailing edge of a cell minus the inset, wrapped to the field
  function automatic coord_t coord_hi(input logic [COORD_W-CELL_SHIFT-1:0] pos);
    coord_hi = {pos, 7'b1111111};
  endfunction

endpackage

### hdl/glyph_cell_allocator_core.sv
// Glyph atlas cell allocator: key search, bump allocation and cell coordinates.
// A blank codepoint skips the key scan; others scan the allocated cells up to a hit, or all
//   of them for a miss.
// Throughput: one request at a time; busy drops in the result cycle, and the scan reads one
//   stored key per cycle from the single read port of the key memory.
// Reset clears the fill count to 1 and the full report; the key store is not cleared, and
//   done is a one-cycle strobe that the receiver cannot stall.
module glyph_cell_allocator_core
  import gca_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int COLUMNS    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_W-1:0]      codepoint,
  output logic                  done,
  output logic [CELL_OUT_W-1:0] cell_index,
  output logic [GRID_W-1:0]     cell_column,
  output logic [GRID_W-1:0]     cell_row,
  output logic [COORD_W-1:0]    s_left,
  output logic [COORD_W-1:0]    t_top,
  output logic [COORD_W-1:0]    s_right,
  output logic [COORD_W-1:0]    t_bottom,
  output logic                  needs_bake,
  output logic                  atlas_full,
  output logic                  first_full_report
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int REM_W = $clog2(COLUMNS) + 2;
  localparam int POS_W = COORD_W - CELL_SHIFT;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOT_COUNT);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_LOAD   = 2'd2;
  localparam logic [1:0] S_DIV    = 2'd3;

  logic [1:0]       state;
  key_t             key;
  logic [IDX_W-1:0] cell_sel;
  logic             bake_flag;
  logic             full_flag;
  logic             first_flag;
  logic [CNT_W-1:0] next_free_cell;
  logic             full_reported;

  logic [CNT_W-1:0] issue_idx;
  logic             issue;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_cell;
  key_t             rd_data;
  logic             match;
  logic             scan_over;
  logic             mem_we;

  key_t             cell_keys [SLOT_COUNT];

  logic             div_start;
  logic             div_done;
  logic [IDX_W-1:0] div_quo;
  logic [REM_W-1:0] div_rem;
  logic [15:0]      col_wide;
  logic [15:0]      row_wide;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;

  // Scan control: issue one allocated cell per cycle, compare its registered read in the following cycle
  always_comb begin
    issue     = (state == S_SEARCH) && (issue_idx < next_free_cell);
    match     = rd_valid && (rd_data == key);
    scan_over = (state == S_SEARCH) && !match && !rd_valid && !issue;
    mem_we    = scan_over && (next_free_cell != SLOTS_C);
    div_start = (state == S_LOAD);
  end

  // Key store: one read port for the scan, one write for a new allocation
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_keys[next_free_cell[IDX_W-1:0]] <= key;
    end
    if (issue) begin
      rd_data <= cell_keys[issue_idx[IDX_W-1:0]];
    end
    rd_cell <= issue_idx[IDX_W-1:0];
  end

  // Sequencer and allocation state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      next_free_cell <= CNT_W'(1);
      full_reported  <= 1'b0;
      rd_valid       <= 1'b0;
      issue_idx      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_valid <= 1'b0;
          if (start) begin
            if (is_blank(codepoint)) begin
              state <= S_LOAD;
            end else begin
              state     <= S_SEARCH;
              issue_idx <= CNT_W'(1);
            end
          end
        end
        S_SEARCH: begin
          rd_valid <= issue && !match;
          if (issue && !match) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (match) begin
            state <= S_LOAD;
          end else if (scan_over) begin
            state <= S_LOAD;
            if (next_free_cell != SLOTS_C) begin
              next_free_cell <= next_free_cell + 1'b1;
            end else begin
              full_reported <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload: key, chosen cell and flags
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      key        <= codepoint;
      cell_sel   <= '0;
      bake_flag  <= 1'b0;
      full_flag  <= 1'b0;
      first_flag <= 1'b0;
    end else if (match) begin
      cell_sel <= rd_cell;
    end else if (scan_over) begin
      if (next_free_cell != SLOTS_C) begin
        cell_sel  <= next_free_cell[IDX_W-1:0];
        bake_flag <= 1'b1;
      end else begin
        cell_sel   <= '0;
        full_flag  <= 1'b1;
        first_flag <= !full_reported;
      end
    end
  end

  // Split the cell into column and row
  gca_divider #(
    .DIVIDEND_W (IDX_W),
    .DIVISOR    (COLUMNS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cell_sel),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    col_wide = 16'(div_rem);
    row_wide = 16'(div_quo);
    col_pos  = col_wide[POS_W-1:0];
    row_pos  = row_wide[POS_W-1:0];
  end

  // Result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_DIV) && div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      cell_index        <= CELL_OUT_W'(cell_sel);
      cell_column       <= col_wide[GRID_W-1:0];
      cell_row          <= row_wide[GRID_W-1:0];
      s_left            <= coord_lo(col_pos);
      t_top             <= coord_lo(row_pos);
      s_right           <= coord_hi(col_pos);
      t_bottom          <= coord_hi(row_pos);
      needs_bake        <= bake_flag;
      atlas_full        <= full_flag;
      first_full_report <= first_flag;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (next_free_cell != '0) && (next_free_cell <= SLOTS_C))
    else $error("fill count out of range");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(needs_bake && atlas_full))
    else $error("bake and full raised together");

  a_first_implies_full: assert property (@(posedge clk) disable iff (rst)
    done && first_full_report |-> atlas_full && cell_index == '0)
    else $error("first full report without full fallback");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in flight");
`endif

endmodule

### hdl/gca_divider.sv
// Constant divider by reciprocal multiplication: the quotient is registered on start, the remainder on step.
module gca_divider #(
  parameter int DIVIDEND_W = 10,
  parameter int DIVISOR    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DIVIDEND_W-1:0]           dividend,
  output logic                            done,
  output logic [DIVIDEND_W-1:0]           quotient,
  output logic [$clog2(DIVISOR)+1:0]      remainder
);

  localparam int RW    = $clog2(DIVISOR) + 2;
  localparam int SH    = DIVIDEND_W + $clog2(DIVISOR);
  localparam int PW    = SH + DIVIDEND_W + 2;
  localparam int RECIP = ((1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [PW-1:0] RECIP_C = PW'(RECIP);
  localparam logic [PW-1:0] DIV_C   = PW'(DIVISOR);

  logic                  step;
  logic [DIVIDEND_W-1:0] num;
  logic [DIVIDEND_W-1:0] quo;
  logic [RW-1:0]         rem;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         back;
  logic [PW-1:0]         diff;

  // Scale by the rounded-up reciprocal, then take back the quotient times the divisor
  always_comb begin
    prod = PW'(dividend) * RECIP_C;
    back = PW'(quo) * DIV_C;
    diff = PW'(num) - back;
  end

  // Sequence the two steps
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 1'b0;
      done <= 1'b0;
    end else begin
      step <= start;
      done <= step;
    end
  end

  // Hold the working registers
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      quo <= prod[SH +: DIVIDEND_W];
    end
    if (step) begin
      rem <= diff[RW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### tb/sv/tb_glyph_cell_allocator_core.sv
`timescale 1ns / 100ps
// Testbench for the glyph cell allocator: directed lookups and random traffic.
module tb_glyph_cell_allocator_core;
  import gca_pkg::*;

  localparam int SLOT_COUNT     = 1024;
  localparam int COLUMNS        = 32;
  localparam int CELL_UNITS     = 128;
  localparam int DIRECTED_ROWS  = 16;
  localparam int RANDOM_ITEMS   = 384;
  // slowest request is a full miss scan over every allocated cell
  localparam int STALL_LIMIT    = 8 * SLOT_COUNT;
  localparam int DRAIN_CYCLES   = SLOT_COUNT + 64;

  typedef struct packed {
    logic [CELL_OUT_W-1:0] cell_index;
    logic [GRID_W-1:0]     cell_column;
    logic [GRID_W-1:0]     cell_row;
    coord_t                s_left;
    coord_t                t_top;
    coord_t                s_right;
    coord_t                t_bottom;
    logic                  needs_bake;
    logic                  atlas_full;
    logic                  first_full_report;
  } cell_result_t;

  typedef struct packed {
    key_t         cp;
    logic         typed;
    cell_result_t want;
  } stim_row_t;

  localparam cell_result_t BLANK_CELL = '{10'd0, 5'd0, 5'd0, 13'd1, 13'd1, 13'd127, 13'd127,
                                          1'b0, 1'b0, 1'b0};
  localparam cell_result_t FIRST_CELL = '{10'd1, 5'd1, 5'd0, 13'd129, 13'd1, 13'd255, 13'd127,
                                          1'b1, 1'b0, 1'b0};
  localparam cell_result_t FIRST_HIT  = '{10'd1, 5'd1, 5'd0, 13'd129, 13'd1, 13'd255, 13'd127,
                                          1'b0, 1'b0, 1'b0};
  localparam cell_result_t SECOND_CELL = '{10'd2, 5'd2, 5'd0, 13'd257, 13'd1, 13'd383, 13'd127,
                                           1'b1, 1'b0, 1'b0};

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [KEY_W-1:0]      codepoint;
  logic                  done;
  logic [CELL_OUT_W-1:0] cell_index;
  logic [GRID_W-1:0]     cell_column;
  logic [GRID_W-1:0]     cell_row;
  logic [COORD_W-1:0]    s_left;
  logic [COORD_W-1:0]    t_top;
  logic [COORD_W-1:0]    s_right;
  logic [COORD_W-1:0]    t_bottom;
  logic                  needs_bake;
  logic                  atlas_full;
  logic                  first_full_report;

  // Shadow of the allocator state
  int           atlas_keys [key_t];
  key_t         baked_keys [$];
  int           fill_next;
  logic         full_flagged;

  cell_result_t cells_in_flight [$];
  stim_row_t    directed_rows [DIRECTED_ROWS];
  int           errors = 0;
  int           idle_cycles = 0;

  glyph_cell_allocator_core #(
    .SLOT_COUNT(SLOT_COUNT),
    .COLUMNS   (COLUMNS)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .codepoint        (codepoint),
    .done             (done),
    .cell_index       (cell_index),
    .cell_column      (cell_column),
    .cell_row         (cell_row),
    .s_left           (s_left),
    .t_top            (t_top),
    .s_right          (s_right),
    .t_bottom         (t_bottom),
    .needs_bake       (needs_bake),
    .atlas_full       (atlas_full),
    .first_full_report(first_full_report)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Look up or allocate the cell for a codepoint and advance the shadow state
  function automatic cell_result_t lookup_cell(key_t cp);
    cell_result_t r;
    int           slot;
    int           col;
    int           row;
    r    = '0;
    slot = 0;
    if (cp != CP_NULL && cp != CP_SPACE) begin
      if (atlas_keys.exists(cp)) begin
        slot = atlas_keys[cp];
      end else if (fill_next < SLOT_COUNT) begin
        slot = fill_next;
        atlas_keys[cp] = slot;
        baked_keys.push_back(cp);
        fill_next++;
        r.needs_bake = 1'b1;
      end else begin
        r.atlas_full        = 1'b1;
        r.first_full_report = !full_flagged;
        full_flagged        = 1'b1;
      end
    end
    col = slot % COLUMNS;
    row = slot / COLUMNS;
    r.cell_index  = CELL_OUT_W'(slot);
    r.cell_column = GRID_W'(col);
    r.cell_row    = GRID_W'(row);
    r.s_left      = COORD_W'(col * CELL_UNITS + 1);
    r.t_top       = COORD_W'(row * CELL_UNITS + 1);
    r.s_right     = COORD_W'((col + 1) * CELL_UNITS - 1);
    r.t_bottom    = COORD_W'((row + 1) * CELL_UNITS - 1);
    return r;
  endfunction

  // Draw a codepoint that has no cell yet, often a small one
  function automatic key_t fresh_key();
    key_t k;
    do begin
      if ($urandom_range(0, 99) < 30) k = KEY_W'($urandom_range(1, 255));
      else k = KEY_W'($urandom);
    end while (k == CP_NULL || k == CP_SPACE || atlas_keys.exists(k));
    return k;
  endfunction

  function automatic key_t pick_baked();
    return baked_keys[$urandom_range(0, baked_keys.size() - 1)];
  endfunction

  function automatic key_t pick_blank();
    return ($urandom_range(0, 1) != 0) ? CP_SPACE : CP_NULL;
  endfunction

  // Hold a request until accepted, then record its expected cell
  task automatic issue_request(key_t cp, logic typed, cell_result_t want, logic gaps_on);
    cell_result_t predicted;
    if (gaps_on && $urandom_range(0, 99) < 18) begin
      // drop start until the block is free, then idle a little longer
      start <= 1'b0;
      do @(posedge clk); while (busy);
      while ($urandom_range(0, 99) < 18) @(posedge clk);
    end
    start     <= 1'b1;
    codepoint <= cp;
    do @(posedge clk); while (busy);
    predicted = lookup_cell(cp);
    cells_in_flight.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each result strobe with the oldest outstanding request
  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && done) begin
      if (cells_in_flight.size() == 0) begin
        $error("cell_index: expected no result, actual %0d", cell_index);
        errors++;
      end else begin
        want = cells_in_flight.pop_front();
        check_field("cell_index", want.cell_index, cell_index);
        check_field("cell_column", want.cell_column, cell_column);
        check_field("cell_row", want.cell_row, cell_row);
        check_field("s_left", want.s_left, s_left);
        check_field("t_top", want.t_top, t_top);
        check_field("s_right", want.s_right, s_right);
        check_field("t_bottom", want.t_bottom, t_bottom);
        check_field("needs_bake", want.needs_bake, needs_bake);
        check_field("atlas_full", want.atlas_full, atlas_full);
        check_field("first_full_report", want.first_full_report, first_full_report);
      end
    end
  end

  // Abort when neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    key_t cp;
    int   pick;
    rst       <= 1'b1;
    start     <= 1'b0;
    codepoint <= '0;
    fill_next    = 1;
    full_flagged = 1'b0;

    // blanks, extremes of the key, first hits, then keys for the predictor
    directed_rows = '{
      '{CP_NULL,       1'b1, BLANK_CELL},
      '{CP_SPACE,      1'b1, BLANK_CELL},
      '{21'd1114111,   1'b1, FIRST_CELL},
      '{21'h1FFFFF,    1'b1, SECOND_CELL},
      '{21'd1114111,   1'b1, FIRST_HIT},
      '{21'd1,         1'b0, '0},
      '{21'd31,        1'b0, '0},
      '{21'd33,        1'b0, '0},
      '{21'h100000,    1'b0, '0},
      '{21'h0AAAAA,    1'b0, '0},
      '{21'h155555,    1'b0, '0},
      '{CP_NULL,       1'b1, BLANK_CELL},
      '{21'h1FFFFF,    1'b0, '0},
      '{21'd65,        1'b0, '0},
      '{21'd1,         1'b0, '0},
      '{21'd64,        1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].cp, directed_rows[i].typed, directed_rows[i].want, 1'b1);

    // mixed blanks, hits and new keys; a middle stretch runs without gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) cp = pick_blank();
      else if (pick < 52) cp = pick_baked();
      else cp = fresh_key();
      issue_request(cp, 1'b0, '0, (i < 150 || i >= 250));
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (cells_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && cells_in_flight.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
